[rtl/core/rrtt_pkg.sv]
// Shared constants and types for the round-robin task table unit.
package rrtt_pkg;

    // Default number of task slots
    localparam int MAX_TASKS_DEFAULT = 16;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int HANDLE_W = 64;
    localparam int SLOT_W   = 4;

    // Stream widths: input data is entry then arg; result is ok, slot, entry, arg
    localparam int S_TDATA_W = 2 * HANDLE_W;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_FIELD_W = 1 + SLOT_W + 2 * HANDLE_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE = 2'd0,
        MODE_SELECT = 2'd1,
        MODE_EXIT   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

endpackage

[rtl/core/round_robin_task_table_unit.sv]
// Round-robin task table: slot table, create/select/exit/clear sequencer.
//
// One transaction on the s_ side carries an operation (tuser) and, for create,
// an entry and an argument handle (tdata). The unit works on one transaction at
// a time and returns exactly one result on the m_ side. Exit, clear and failed
// early checks go from ST_START straight to ST_OUT; create scans up to
// MAX_TASKS slots and select up to slot_count slots, testing one slot per
// cycle through a single index counter and compare. s_tready is high only
// while the sequencer is idle; a finished result may still wait in the output
// register while the next transaction is taken. Handle tables are memories with
// a registered read; they are only read for slots created since the last clear,
// so they need no clearing pass.
module round_robin_task_table_unit #(
    parameter int MAX_TASKS = rrtt_pkg::MAX_TASKS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata, low bit up: entry_handle[63:0], arg_handle[127:64]
    input  logic [rrtt_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser, low bit up: mode[1:0]
    input  logic [rrtt_pkg::S_TUSER_W-1:0] s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata, low bit up: ok[0], slot[4:1], task_entry[68:5], task_arg[132:69],
    // zero fill[135:133]
    output logic [rrtt_pkg::M_TDATA_W-1:0] m_tdata
);
    import rrtt_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] NO_CURRENT = CNT_W'(MAX_TASKS);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(MAX_TASKS - 1);

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_CREATE = 5'b00100,
        ST_SELECT = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [HANDLE_W-1:0]    entry_reg, entry_next;
    logic [HANDLE_W-1:0]    arg_reg, arg_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       step_reg, step_next;
    logic [MAX_TASKS-1:0]   active_reg, active_next;
    logic [MAX_TASKS-1:0]   finished_reg, finished_next;
    logic [CNT_W-1:0]       current_reg, current_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]       res_slot_reg, res_slot_next;
    logic                   res_sel_reg, res_sel_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg;

    // Handle tables
    logic [HANDLE_W-1:0]    entry_mem [MAX_TASKS];
    logic [HANDLE_W-1:0]    arg_mem   [MAX_TASKS];
    logic [HANDLE_W-1:0]    entry_rd_reg;
    logic [HANDLE_W-1:0]    arg_rd_reg;
    logic                   mem_we;

    logic                   s_accept;
    logic                   out_free;
    logic [CNT_W-1:0]       cur_plus;
    logic [CNT_W-1:0]       idx_plus;
    logic [CNT_W-1:0]       step_plus;
    logic [SLOT_W+IDX_W-1:0] slot_ext;
    logic [HANDLE_W-1:0]    out_entry;
    logic [HANDLE_W-1:0]    out_arg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cur_plus  = current_reg + CNT_W'(1);
    assign idx_plus  = CNT_W'(idx_reg) + CNT_W'(1);
    assign step_plus = step_reg + CNT_W'(1);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        entry_next    = entry_reg;
        arg_next      = arg_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        active_next   = active_reg;
        finished_next = finished_reg;
        current_next  = current_reg;
        count_next    = count_reg;
        res_ok_next   = res_ok_reg;
        res_slot_next = res_slot_reg;
        res_sel_next  = res_sel_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mem_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    mode_next  = mode_t'(s_tuser);
                    entry_next = s_tdata[HANDLE_W-1:0];
                    arg_next   = s_tdata[2*HANDLE_W-1:HANDLE_W];
                    state_next = ST_START;
                end
            end
            ST_START: begin
                // Default to a failed, non-select result
                res_ok_next   = 1'b0;
                res_slot_next = '0;
                res_sel_next  = 1'b0;
                step_next     = '0;
                unique case (mode_reg)
                    MODE_CREATE: begin
                        if (entry_reg == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_CREATE;
                        end
                    end
                    MODE_SELECT: begin
                        if (count_reg == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            if (current_reg == NO_CURRENT || cur_plus == count_reg) begin
                                idx_next = '0;
                            end else begin
                                idx_next = cur_plus[IDX_W-1:0];
                            end
                            state_next = ST_SELECT;
                        end
                    end
                    MODE_EXIT: begin
                        if (current_reg != NO_CURRENT) begin
                            finished_next[current_reg[IDX_W-1:0]] = 1'b1;
                            res_ok_next   = 1'b1;
                            res_slot_next = current_reg[IDX_W-1:0];
                        end
                        state_next = ST_OUT;
                    end
                    MODE_CLEAR: begin
                        active_next   = '0;
                        finished_next = '0;
                        res_ok_next   = 1'b1;
                        state_next    = ST_OUT;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_CREATE: begin
                // Test one slot per cycle, lowest first
                if (!active_reg[idx_reg]) begin
                    mem_we                 = 1'b1;
                    active_next[idx_reg]   = 1'b1;
                    finished_next[idx_reg] = 1'b0;
                    if (idx_plus > count_reg) begin
                        count_next = idx_plus;
                    end
                    res_ok_next   = 1'b1;
                    res_slot_next = idx_reg;
                    state_next    = ST_OUT;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = ST_OUT;
                end else begin
                    idx_next = idx_plus[IDX_W-1:0];
                end
            end
            ST_SELECT: begin
                // Walk from the start slot, wrap at the count
                if (active_reg[idx_reg] && !finished_reg[idx_reg]) begin
                    current_next  = CNT_W'(idx_reg);
                    res_ok_next   = 1'b1;
                    res_slot_next = idx_reg;
                    res_sel_next  = 1'b1;
                    state_next    = ST_OUT;
                end else if (step_plus == count_reg) begin
                    state_next = ST_OUT;
                end else begin
                    step_next = step_plus;
                    if (idx_plus == count_reg) begin
                        idx_next = '0;
                    end else begin
                        idx_next = idx_plus[IDX_W-1:0];
                    end
                end
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result fields
    assign slot_ext  = {{SLOT_W{1'b0}}, res_slot_reg};
    assign out_entry = res_sel_reg ? entry_rd_reg : '0;
    assign out_arg   = res_sel_reg ? arg_rd_reg : '0;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= '0;
            finished_reg <= '0;
            current_reg  <= NO_CURRENT;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            finished_reg <= finished_next;
            current_reg  <= current_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        entry_reg    <= entry_next;
        arg_reg      <= arg_next;
        idx_reg      <= idx_next;
        step_reg     <= step_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        res_sel_reg  <= res_sel_next;
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {{(M_TDATA_W - M_FIELD_W){1'b0}}, out_arg, out_entry,
                            slot_ext[SLOT_W-1:0], res_ok_reg};
        end
    end

    // Handle tables: write on create, registered read at the scan index
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[idx_reg] <= entry_reg;
            arg_mem[idx_reg]   <= arg_reg;
        end
        entry_rd_reg <= entry_mem[idx_reg];
        arg_rd_reg   <= arg_mem[idx_reg];
    end

    // Checks
    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("slot count decreased");

    a_current_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        current_reg != NO_CURRENT |-> current_reg < count_reg)
        else $error("current slot outside the slot count");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_START)
        else $error("accepted transaction did not start");

    a_select_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SELECT |-> step_reg < count_reg && CNT_W'(idx_reg) < count_reg)
        else $error("select scan ran past the slot count");

    a_create_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CREATE |-> entry_reg != '0)
        else $error("create scan started with a zero entry handle");

endmodule
